// ----- sv/mbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan package
// Shared constants, register indexes and the structures passed between the
// front stage, the match stage and the result queue.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int OFFSET_BITS = 32;
	localparam int ADDR_W      = 48;
	localparam int LEN_W       = 5;
	localparam int MASK_W      = 16;
	localparam int LIMIT_W     = 16;
	localparam int PAT_BYTES   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 3'd5;

	typedef logic [MAX_PATTERN-1:0][7:0] window_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [MASK_W-1:0]         mask;
		logic [LEN_W-1:0]          length;
		logic [LIMIT_W-1:0]        limit;
		logic [ADDR_W-1:0]         base;
	} cfg_t;

	typedef struct packed {
		logic                   was_full;
		logic                   final_b;
		logic                   long_enough;
		logic [OFFSET_BITS-1:0] offset;
	} stage_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              is_match;
		logic              run_done;
	} result_t;

endpackage

// ----- sv/mbps_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan front stage
// Shifts accepted bytes into the window, keeps the saturating byte count and
// registers the per-byte offset information for the match stage.
// ----------------------------------------------------------------------------
module mbps_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_fire,
	input  logic                             take_s1,
	input  logic [7:0]                       data_byte,
	input  logic                             final_byte,
	input  logic [mbps_pkg::LEN_W-1:0]       pattern_length,
	output logic                             valid_s1,
	output mbps_pkg::stage_t                 stage_s1,
	output mbps_pkg::window_t                window_q
);

	logic [mbps_pkg::OFFSET_BITS-1:0] cnt_q;
	logic [mbps_pkg::OFFSET_BITS-1:0] cnt_nxt;
	logic [mbps_pkg::OFFSET_BITS-1:0] len_ext;
	logic                             was_full;
	logic                             valid_s1_q;

	assign was_full = &cnt_q;
	assign cnt_nxt  = was_full ? cnt_q : cnt_q + mbps_pkg::OFFSET_BITS'(1);
	assign len_ext  = mbps_pkg::OFFSET_BITS'(pattern_length);
	assign valid_s1 = valid_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			valid_s1_q <= 1'b0;
		end else begin
			if (in_fire) begin
				cnt_q      <= final_byte ? '0 : cnt_nxt;
				valid_s1_q <= 1'b1;
			end else if (take_s1) begin
				valid_s1_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int k = mbps_pkg::MAX_PATTERN - 1; k > 0; k--) begin
				window_q[k] <= window_q[k-1];
			end
			window_q[0]          <= data_byte;
			stage_s1.was_full    <= was_full;
			stage_s1.final_b     <= final_byte;
			stage_s1.long_enough <= (cnt_nxt >= len_ext);
			stage_s1.offset      <= cnt_nxt - len_ext;
		end
	end

endmodule

// ----- sv/mbps_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan match stage
// Compares the window with the masked pattern, applies the match limit and
// forms up to two results per byte for the result queue.
// ----------------------------------------------------------------------------
module mbps_match (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid_s1,
	input  mbps_pkg::stage_t      stage_s1,
	input  mbps_pkg::window_t     window_q,
	input  mbps_pkg::cfg_t        cfg,
	input  logic                  room,
	output logic                  take_s1,
	output logic [1:0]            push_cnt,
	output mbps_pkg::result_t     res0,
	output mbps_pkg::result_t     res1
);

	logic [mbps_pkg::LIMIT_W-1:0] found_q;
	logic                         window_ok;
	logic                         len_valid;
	logic                         limit_ok;
	logic                         hit;
	mbps_pkg::result_t            match_res;
	mbps_pkg::result_t            end_res;

	always_comb begin
		logic [mbps_pkg::LEN_W-1:0] idx;
		window_ok = 1'b1;
		for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++) begin
			idx = cfg.length - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
			if ((mbps_pkg::LEN_W'(i) < cfg.length) && cfg.mask[i] &&
			    (window_q[idx[mbps_pkg::WIN_IDX_W-1:0]] != cfg.pattern[i])) begin
				window_ok = 1'b0;
			end
		end
	end

	assign len_valid = (cfg.length != '0) &&
	                   (cfg.length <= mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN));
	assign limit_ok  = (cfg.limit == '0) || (found_q < cfg.limit);
	assign hit       = !stage_s1.was_full && len_valid && stage_s1.long_enough &&
	                   limit_ok && window_ok;
	assign take_s1   = valid_s1 && room;

	assign match_res.address  = cfg.base + mbps_pkg::ADDR_W'(stage_s1.offset);
	assign match_res.is_match = 1'b1;
	assign match_res.run_done = 1'b0;
	assign end_res.address    = '0;
	assign end_res.is_match   = 1'b0;
	assign end_res.run_done   = 1'b1;

	always_comb begin
		res0     = hit ? match_res : end_res;
		res1     = end_res;
		push_cnt = 2'd0;
		if (take_s1) begin
			push_cnt = 2'(hit) + 2'(stage_s1.final_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (take_s1) begin
			if (stage_s1.final_b) begin
				found_q <= '0;
			end else if (hit && !(&found_q)) begin
				found_q <= found_q + mbps_pkg::LIMIT_W'(1);
			end
		end
	end

endmodule

// ----- sv/mbps_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan result queue
// A small queue that takes up to two results per cycle and hands them to the
// output channel one per transaction.
// ----------------------------------------------------------------------------
module mbps_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  mbps_pkg::result_t   res0,
	input  mbps_pkg::result_t   res1,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output mbps_pkg::result_t   head
);

	mbps_pkg::result_t                  mem_q [mbps_pkg::FIFO_DEPTH];
	logic [mbps_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [mbps_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [mbps_pkg::FIFO_CNT_W-1:0]    cnt_q;
	logic                               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= mbps_pkg::FIFO_CNT_W'(mbps_pkg::FIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + mbps_pkg::FIFO_PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + mbps_pkg::FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + mbps_pkg::FIFO_CNT_W'(push_cnt) - mbps_pkg::FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_q + mbps_pkg::FIFO_PTR_W'(1)] <= res1;
		end
	end

endmodule

// ----- sv/masked_byte_pattern_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan
// Searches a byte stream for a pattern of up to 16 bytes with wildcards.
// ----------------------------------------------------------------------------
// Bytes enter on the input channel (in_valid, in_ready, data_byte,
// final_byte) and results leave on the output channel (out_valid, out_ready,
// match_address, is_match, run_done). Each byte may give a match result and,
// when it is the region's last byte, an end result after it.
// Configuration is written through cfg_we, cfg_index and cfg_data. The user
// must write only while no transaction is in flight, unchecked by the block.
// A byte is registered into the window on acceptance, compared from that
// register and, once the result queue has room, its results are written into
// the queue, from which the output channel shows them.
// One byte is accepted per cycle while each byte gives at most one result
// and the receiver keeps up; a byte giving two results needs two output
// transactions, as the four-entry result queue has a single output port.
// Reset clears the counters, the queue and all configuration registers.
// When the receiver stalls, the queue fills and in_ready falls once fewer
// than two entries are free, so no result is ever dropped.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                final_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mbps_pkg::ADDR_W-1:0]         match_address,
	output logic                                is_match,
	output logic                                run_done,
	input  logic                                cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mbps_pkg::cfg_t     cfg_q;
	mbps_pkg::stage_t   stage_s1;
	mbps_pkg::window_t  window_q;
	mbps_pkg::result_t  res0;
	mbps_pkg::result_t  res1;
	mbps_pkg::result_t  head;
	logic               valid_s1;
	logic               take_s1;
	logic               room;
	logic               in_fire;
	logic [1:0]         push_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mbps_pkg::REG_PATTERN_LOW: begin
					cfg_q.pattern[7:0] <= cfg_data;
				end
				mbps_pkg::REG_PATTERN_HIGH: begin
					cfg_q.pattern[15:8] <= cfg_data;
				end
				mbps_pkg::REG_COMPARE_MASK: begin
					cfg_q.mask <= cfg_data[mbps_pkg::MASK_W-1:0];
				end
				mbps_pkg::REG_PATTERN_LEN: begin
					cfg_q.length <= cfg_data[mbps_pkg::LEN_W-1:0];
				end
				mbps_pkg::REG_MATCH_LIMIT: begin
					cfg_q.limit <= cfg_data[mbps_pkg::LIMIT_W-1:0];
				end
				mbps_pkg::REG_REGION_BASE: begin
					cfg_q.base <= cfg_data[mbps_pkg::ADDR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ready = !valid_s1 || take_s1;
	assign in_fire  = in_valid && in_ready;

	mbps_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.take_s1        (take_s1),
		.data_byte      (data_byte),
		.final_byte     (final_byte),
		.pattern_length (cfg_q.length),
		.valid_s1       (valid_s1),
		.stage_s1       (stage_s1),
		.window_q       (window_q)
	);

	mbps_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.window_q (window_q),
		.cfg      (cfg_q),
		.room     (room),
		.take_s1  (take_s1),
		.push_cnt (push_cnt),
		.res0     (res0),
		.res1     (res1)
	);

	mbps_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign match_address = head.address;
	assign is_match      = head.is_match;
	assign run_done      = head.run_done;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked byte pattern scan testbench
// Drives byte regions through the scanner under random flow control and
// compares every result transaction with a scan model kept in the bench.
// ----------------------------------------------------------------------------
// A short directed part covers the reset state, single-byte patterns with
// address wrap, over-long and zero lengths, regions shorter than the pattern,
// the match limit and mask bits beyond the pattern length. A back-pressure
// test stalls the receiver for a long stretch while bytes keep coming. The
// random part then plants the configured pattern, with random wildcard
// content, into random regions under many register settings.
// ----------------------------------------------------------------------------
module tb;

	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 380;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [7:0]                      data_byte;
	logic                            final_byte;
	logic                            out_valid;
	logic                            out_ready;
	logic [mbps_pkg::ADDR_W-1:0]     match_address;
	logic                            is_match;
	logic                            run_done;
	logic                            cfg_we;
	logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;

	// Register copies and scan state of the bench model.
	logic [63:0]                      pat_lo;
	logic [63:0]                      pat_hi;
	logic [mbps_pkg::MASK_W-1:0]      cmp_mask;
	logic [mbps_pkg::LEN_W-1:0]       pat_len;
	logic [mbps_pkg::LIMIT_W-1:0]     limit_cfg;
	logic [mbps_pkg::ADDR_W-1:0]      base_cfg;
	logic [7:0]                       window_q [mbps_pkg::MAX_PATTERN];
	logic [mbps_pkg::OFFSET_BITS-1:0] seen_count;
	logic [mbps_pkg::LIMIT_W-1:0]     hits_in_region;

	mbps_pkg::result_t pending_results [$];
	int                mismatches;
	int                bytes_sent;
	int                burst_left;
	int                hold_request;

	masked_byte_pattern_scan uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.final_byte    (final_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_address (match_address),
		.is_match      (is_match),
		.run_done      (run_done),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [7:0] pattern_byte_at(input int i);
		if (i < 8) begin
			return pat_lo[i*8 +: 8];
		end else begin
			return pat_hi[(i-8)*8 +: 8];
		end
	endfunction

	function automatic void expect_result(input mbps_pkg::result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic last);
		logic                             was_full;
		logic                             hit;
		logic [mbps_pkg::OFFSET_BITS-1:0] offset;
		mbps_pkg::result_t                r;
		was_full = (seen_count == '1);
		for (int k = mbps_pkg::MAX_PATTERN - 1; k > 0; k--)
			window_q[k] = window_q[k-1];
		window_q[0] = b;
		if (!was_full)
			seen_count++;
		hit = !was_full && pat_len != 0 && pat_len <= mbps_pkg::MAX_PATTERN &&
			seen_count >= pat_len && (limit_cfg == 0 || hits_in_region < limit_cfg);
		for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++) begin
			if (hit && i < pat_len && cmp_mask[i]) begin
				if (window_q[pat_len-1-i] != pattern_byte_at(i))
					hit = 1'b0;
			end
		end
		if (hit) begin
			offset = seen_count - pat_len;
			r.address = base_cfg + offset;
			r.is_match = 1'b1;
			r.run_done = 1'b0;
			expect_result(r);
			if (hits_in_region != '1)
				hits_in_region++;
		end
		if (last) begin
			r.address = '0;
			r.is_match = 1'b0;
			r.run_done = 1'b1;
			expect_result(r);
			seen_count = '0;
			hits_in_region = '0;
		end
	endfunction

	// Configuration writes and input transactions feed the model; each output
	// transaction is compared with the oldest expected result.
	always @(posedge clk) begin : scoreboard
		mbps_pkg::result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					mbps_pkg::REG_PATTERN_LOW:  pat_lo = cfg_data;
					mbps_pkg::REG_PATTERN_HIGH: pat_hi = cfg_data;
					mbps_pkg::REG_COMPARE_MASK: cmp_mask = cfg_data[mbps_pkg::MASK_W-1:0];
					mbps_pkg::REG_PATTERN_LEN:  pat_len = cfg_data[mbps_pkg::LEN_W-1:0];
					mbps_pkg::REG_MATCH_LIMIT:  limit_cfg = cfg_data[mbps_pkg::LIMIT_W-1:0];
					mbps_pkg::REG_REGION_BASE:  base_cfg = cfg_data[mbps_pkg::ADDR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				scan_byte(data_byte, final_byte);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: match_address %h is_match %b run_done %b",
						match_address, is_match, run_done);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (match_address !== want.address) begin
						$error("match_address: expected %h, actual %h",
							want.address, match_address);
						mismatches++;
					end
					if (is_match !== want.is_match) begin
						$error("is_match: expected %b, actual %b", want.is_match, is_match);
						mismatches++;
					end
					if (run_done !== want.run_done) begin
						$error("run_done: expected %b, actual %b", want.run_done, run_done);
						mismatches++;
					end
				end
			end
		end
	end

	// The receiver switches between random stall patterns and honours
	// a requested hold-off, which it counts down itself.
	initial begin : receiver
		int hold_left;
		int mode_left;
		int mode;
		out_ready = 1'b0;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 4) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		bytes_sent++;
	endtask

	task automatic settle_scan();
		@(negedge clk) in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbps_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
			input logic [mbps_pkg::MASK_W-1:0] mask, input logic [mbps_pkg::LEN_W-1:0] len,
			input logic [mbps_pkg::LIMIT_W-1:0] lim, input logic [mbps_pkg::ADDR_W-1:0] base);
		settle_scan();
		write_reg(mbps_pkg::REG_PATTERN_LOW, lo);
		write_reg(mbps_pkg::REG_PATTERN_HIGH, hi);
		write_reg(mbps_pkg::REG_COMPARE_MASK, mbps_pkg::CFG_DATA_W'(mask));
		write_reg(mbps_pkg::REG_PATTERN_LEN, mbps_pkg::CFG_DATA_W'(len));
		write_reg(mbps_pkg::REG_MATCH_LIMIT, mbps_pkg::CFG_DATA_W'(lim));
		write_reg(mbps_pkg::REG_REGION_BASE, mbps_pkg::CFG_DATA_W'(base));
	endtask

	// Planted copies of the pattern take random bytes at wildcard positions;
	// the rest of the region is noise, partly drawn from the pattern bytes.
	task automatic scan_random_region(input int n);
		int          i;
		logic [7:0]  b;
		i = 0;
		while (i < n) begin
			if (pat_len >= 1 && pat_len <= mbps_pkg::MAX_PATTERN &&
			    $urandom_range(0, 2) == 0) begin
				for (int k = 0; k < pat_len && i < n; k++) begin
					b = cmp_mask[k] ? pattern_byte_at(k) : 8'($urandom);
					send_byte(b, i == n - 1);
					i++;
				end
			end else begin
				b = ($urandom_range(0, 3) == 0) ? pattern_byte_at($urandom_range(0, 15))
					: 8'($urandom);
				send_byte(b, i == n - 1);
				i++;
			end
			if ($urandom_range(0, 60) == 0)
				settle_scan();
		end
	endtask

	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_address_wrap();
		load_settings('1, '0, 16'h0001, 5'd1, '0, '1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_length_too_long();
		load_settings('0, '0, '1, 5'd17, '0, '0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		load_settings('0, '0, '1, 5'd31, '0, '0);
		send_byte(8'h00, 1'b1);
	endtask

	task automatic test_short_region();
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd4, '0, '0);
		repeat (2) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
	endtask

	task automatic test_match_limit();
		load_settings('0, '0, '0, 5'd2, 16'd2, 48'h100);
		repeat (3) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
	endtask

	task automatic test_mask_beyond_length();
		load_settings(64'hA55A, '1, '1, 5'd2, '1, '0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
	endtask

	// Every byte matches, so the result queue fills during the hold-off and
	// the input has to stall.
	task automatic test_backpressure();
		load_settings('0, '0, '0, 5'd1, '0, 48'($urandom));
		hold_request = 150;
		for (int i = 0; i < 40; i++)
			send_byte(8'($urandom), i == 39);
		settle_scan();
	endtask

	task automatic test_random_regions();
		int                           target;
		int                           phase;
		logic [mbps_pkg::LEN_W-1:0]   len;
		logic [mbps_pkg::MASK_W-1:0]  mask;
		logic [mbps_pkg::LIMIT_W-1:0] lim;
		logic [mbps_pkg::ADDR_W-1:0]  base;
		target = bytes_sent + RANDOM_BYTES;
		phase = 0;
		while (bytes_sent < target) begin
			case ($urandom_range(0, 9))
				0: len = '0;
				1: len = mbps_pkg::LEN_W'($urandom_range(17, 31));
				2: len = 5'd16;
				default: len = mbps_pkg::LEN_W'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 3))
				0: mask = '1;
				1: mask = '0;
				default: mask = mbps_pkg::MASK_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: lim = mbps_pkg::LIMIT_W'($urandom_range(1, 3));
				1: lim = '1;
				2: lim = mbps_pkg::LIMIT_W'($urandom);
				default: lim = '0;
			endcase
			case ($urandom_range(0, 3))
				0: base = '1 - mbps_pkg::ADDR_W'($urandom_range(0, 40));
				1: base = '0;
				default: base = mbps_pkg::ADDR_W'({$urandom, $urandom});
			endcase
			if (phase == 0) begin
				len = 5'd16;
				mask = '1;
			end
			load_settings({$urandom, $urandom}, {$urandom, $urandom}, mask, len, lim, base);
			repeat ($urandom_range(1, 4))
				scan_random_region(($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
					: $urandom_range(1, 40));
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		final_byte = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pat_lo = '0;
		pat_hi = '0;
		cmp_mask = '0;
		pat_len = '0;
		limit_cfg = '0;
		base_cfg = '0;
		foreach (window_q[k])
			window_q[k] = '0;
		seen_count = '0;
		hits_in_region = '0;
		mismatches = 0;
		bytes_sent = 0;
		burst_left = 0;
		hold_request = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_state();
		test_address_wrap();
		test_length_too_long();
		test_short_region();
		test_match_limit();
		test_mask_beyond_length();
		test_backpressure();
		test_random_regions();
		settle_scan();

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/mbps_pkg.sv
sv/mbps_front.sv
sv/mbps_match.sv
sv/mbps_out_fifo.sv
sv/masked_byte_pattern_scan.sv
tb/sv/tb.sv
